/* design/differential_vector_clock_macros.svh */
// assertion macros for the differential vector clock checker
`ifndef DIFFERENTIAL_VECTOR_CLOCK_MACROS_SVH
`define DIFFERENTIAL_VECTOR_CLOCK_MACROS_SVH

// same-cycle implication, disabled in reset
`define DVC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define DVC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/dvc_pkg.sv */
// shared types and constants of the differential vector clock
package dvc_pkg;

    localparam int DEFAULT_NUM_PROCESSES = 16;
    localparam int IDX_LIMIT             = 16;
    localparam int IDX_W                 = 4;
    localparam int CLK_W                 = 32;

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_TUPLE  = 1'b1;

    typedef enum logic [1:0] {
        FUNC_INTERNAL   = 2'd0,
        FUNC_SEND       = 2'd1,
        FUNC_RECV_BEGIN = 2'd2,
        FUNC_TUPLE      = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_RX_IDX,
        ST_RX_OWN,
        ST_SEND_TICK,
        ST_WALK,
        ST_FLUSH
    } state_t;

endpackage

/* design/dvc_ram.sv */
// generic single-port-write ram with registered read
module dvc_ram #(
    parameter int WIDTH = dvc_pkg::CLK_W,
    parameter int DEPTH = dvc_pkg::IDX_LIMIT
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/differential_vector_clock.sv */
// top level of the differential vector clock
// Keeps one process's vector clock with per-entry last-update stamps and
// per-destination last-sent stamps in two small rams (clock and stamp share
// one word). Items are taken one at a time. An internal event or receive
// begin reads and ticks the own entry; a received tuple reads the clock ram
// twice (indexed entry, then own entry); a send ticks the own entry, then
// walks the N entries kept (NUM_PROCESSES, at most 16) one entry per cycle
// unless a result stall holds it. Stalls on the result side delay every kind
// of item. A result beat may wait in the output register while the next item
// is taken. Own id, destination and tuple index are folded modulo N.
module differential_vector_clock #(
    parameter int NUM_PROCESSES = dvc_pkg::DEFAULT_NUM_PROCESSES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [1:0]  func,
    input  logic [3:0]  destination,
    input  logic [3:0]  tuple_index,
    input  logic [31:0] tuple_value,
    output logic        result_valid,
    input  logic        result_ready,
    output logic        kind,
    output logic [3:0]  entry_index,
    output logic [31:0] entry_value,
    output logic        last
);

    localparam int NENT  = (NUM_PROCESSES < dvc_pkg::IDX_LIMIT) ?
                           NUM_PROCESSES : dvc_pkg::IDX_LIMIT;
    localparam int IW    = $clog2(NENT);
    localparam int CW    = dvc_pkg::CLK_W;
    localparam int XW    = dvc_pkg::IDX_W;

    function automatic logic [IW-1:0] fold_idx(input logic [XW-1:0] v);
        logic [XW:0] r;
        r = {1'b0, v};
        for (int s = 0; s < 8; s++)
        begin
            if (r >= (XW+1)'(NENT))
            begin
                r = r - (XW+1)'(NENT);
            end
        end
        return r[IW-1:0];
    endfunction

    dvc_pkg::state_t state_reg, state_next;

    logic [XW-1:0]  own_id_reg;
    logic [IW-1:0]  me;

    logic [NENT-1:0] vc_vld_reg, vc_vld_next;
    logic [NENT-1:0] sent_vld_reg, sent_vld_next;
    logic            vc_rd_vld_reg, vc_rd_vld_next;
    logic            sent_rd_vld_reg, sent_rd_vld_next;

    logic            vc_wr_en, vc_rd_en, sent_wr_en, sent_rd_en;
    logic [IW-1:0]   vc_wr_addr, vc_rd_addr, sent_wr_addr, sent_rd_addr;
    logic [2*CW-1:0] vc_wr_data, vc_rd_data;
    logic [CW-1:0]   sent_wr_data, sent_rd_data;

    logic [CW-1:0]   vc_clk, vc_stamp, since;

    logic [IW-1:0]   dest_reg, dest_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic [CW-1:0]   tv_reg, tv_next;
    logic [CW-1:0]   ent_clk_reg, ent_clk_next;
    logic [CW-1:0]   own_clk_reg, own_clk_next;
    logic [CW-1:0]   own_stamp_reg, own_stamp_next;
    logic [CW-1:0]   since_reg, since_next;
    logic [IW:0]     rd_cnt_reg, rd_cnt_next;
    logic [IW-1:0]   chk_idx_reg, chk_idx_next;
    logic            chk_valid_reg, chk_valid_next;
    logic            pend_valid_reg, pend_valid_next;
    logic [IW-1:0]   pend_idx_reg, pend_idx_next;
    logic [CW-1:0]   pend_val_reg, pend_val_next;

    logic            out_valid_reg, out_valid_next;
    logic            out_kind_reg, out_kind_next;
    logic [XW-1:0]   out_idx_reg, out_idx_next;
    logic [CW-1:0]   out_val_reg, out_val_next;
    logic            out_last_reg, out_last_next;

    logic            item_fire, out_free, walk_more;
    logic            tick_sat;
    logic [CW-1:0]   tick_clk, tick_stamp;
    logic [CW-1:0]   cur_clk, cur_stamp;
    logic            cur_sel, walk_stall, grow;

    assign cfg_ready    = 1'b1;
    assign item_ready   = (state_reg == dvc_pkg::ST_IDLE);
    assign item_fire    = item_valid && item_ready;
    assign out_free     = !out_valid_reg || result_ready;
    assign me           = fold_idx(own_id_reg);
    assign walk_more    = (rd_cnt_reg < (IW+1)'(NENT));

    assign result_valid = out_valid_reg;
    assign kind         = out_kind_reg;
    assign entry_index  = out_idx_reg;
    assign entry_value  = out_val_reg;
    assign last         = out_last_reg;

    assign vc_clk   = vc_rd_vld_reg ? vc_rd_data[CW-1:0] : '0;
    assign vc_stamp = vc_rd_vld_reg ? vc_rd_data[2*CW-1:CW] : '0;
    assign since    = sent_rd_vld_reg ? sent_rd_data : '0;

    // saturating tick of the own entry
    assign tick_sat   = &vc_clk;
    assign tick_clk   = tick_sat ? vc_clk : vc_clk + CW'(1);
    assign tick_stamp = tick_sat ? vc_stamp : tick_clk;

    // walk entry under check, own entry forwarded
    assign cur_clk    = (chk_idx_reg == me) ? own_clk_reg : vc_clk;
    assign cur_stamp  = (chk_idx_reg == me) ? own_stamp_reg : vc_stamp;
    assign cur_sel    = chk_valid_reg && (since_reg < cur_stamp);
    assign walk_stall = cur_sel && pend_valid_reg && !out_free;

    assign grow = (ent_clk_reg < tv_reg);

    dvc_ram #(
        .WIDTH (2*CW),
        .DEPTH (NENT)
    ) u_clock_ram (
        .clk     (clk),
        .wr_en   (vc_wr_en),
        .wr_addr (vc_wr_addr),
        .wr_data (vc_wr_data),
        .rd_en   (vc_rd_en),
        .rd_addr (vc_rd_addr),
        .rd_data (vc_rd_data)
    );

    dvc_ram #(
        .WIDTH (CW),
        .DEPTH (NENT)
    ) u_sent_ram (
        .clk     (clk),
        .wr_en   (sent_wr_en),
        .wr_addr (sent_wr_addr),
        .wr_data (sent_wr_data),
        .rd_en   (sent_rd_en),
        .rd_addr (sent_rd_addr),
        .rd_data (sent_rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dvc_pkg::ST_IDLE:
            begin
                if (item_fire)
                begin
                    unique case (dvc_pkg::func_t'(func)) inside
                        dvc_pkg::FUNC_SEND:  state_next = dvc_pkg::ST_SEND_TICK;
                        dvc_pkg::FUNC_TUPLE: state_next = dvc_pkg::ST_RX_IDX;
                        dvc_pkg::FUNC_INTERNAL, dvc_pkg::FUNC_RECV_BEGIN:
                            state_next = dvc_pkg::ST_TICK;
                    endcase
                end
            end
            dvc_pkg::ST_TICK:
            begin
                if (out_free)
                begin
                    state_next = dvc_pkg::ST_IDLE;
                end
            end
            dvc_pkg::ST_RX_IDX:
            begin
                state_next = dvc_pkg::ST_RX_OWN;
            end
            dvc_pkg::ST_RX_OWN:
            begin
                if (out_free)
                begin
                    state_next = dvc_pkg::ST_IDLE;
                end
            end
            dvc_pkg::ST_SEND_TICK:
            begin
                state_next = dvc_pkg::ST_WALK;
            end
            dvc_pkg::ST_WALK:
            begin
                if (!chk_valid_reg && !walk_more)
                begin
                    state_next = dvc_pkg::ST_FLUSH;
                end
            end
            dvc_pkg::ST_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = dvc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dvc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        vc_wr_en         = 1'b0;
        vc_wr_addr       = me;
        vc_wr_data       = {tick_stamp, tick_clk};
        vc_rd_en         = 1'b0;
        vc_rd_addr       = me;
        sent_wr_en       = 1'b0;
        sent_wr_addr     = dest_reg;
        sent_wr_data     = tick_clk;
        sent_rd_en       = 1'b0;
        sent_rd_addr     = fold_idx(destination);

        dest_next        = dest_reg;
        idx_next         = idx_reg;
        tv_next          = tv_reg;
        ent_clk_next     = ent_clk_reg;
        own_clk_next     = own_clk_reg;
        own_stamp_next   = own_stamp_reg;
        since_next       = since_reg;
        rd_cnt_next      = rd_cnt_reg;
        chk_idx_next     = chk_idx_reg;
        chk_valid_next   = chk_valid_reg;
        pend_valid_next  = pend_valid_reg;
        pend_idx_next    = pend_idx_reg;
        pend_val_next    = pend_val_reg;

        out_valid_next   = out_valid_reg && !result_ready;
        out_kind_next    = out_kind_reg;
        out_idx_next     = out_idx_reg;
        out_val_next     = out_val_reg;
        out_last_next    = out_last_reg;

        unique case (state_reg)
            dvc_pkg::ST_IDLE:
            begin
                if (item_fire)
                begin
                    dest_next  = fold_idx(destination);
                    idx_next   = fold_idx(tuple_index);
                    tv_next    = tuple_value;
                    vc_rd_en   = 1'b1;
                    if (dvc_pkg::func_t'(func) == dvc_pkg::FUNC_TUPLE)
                    begin
                        vc_rd_addr = fold_idx(tuple_index);
                    end
                    if (dvc_pkg::func_t'(func) == dvc_pkg::FUNC_SEND)
                    begin
                        sent_rd_en = 1'b1;
                    end
                end
            end
            dvc_pkg::ST_TICK:
            begin
                if (out_free)
                begin
                    vc_wr_en       = !tick_sat;
                    out_valid_next = 1'b1;
                    out_kind_next  = dvc_pkg::KIND_REPORT;
                    out_idx_next   = XW'(me);
                    out_val_next   = tick_clk;
                    out_last_next  = 1'b1;
                end
            end
            dvc_pkg::ST_RX_IDX:
            begin
                ent_clk_next = vc_clk;
                vc_rd_en     = 1'b1;
                vc_rd_addr   = me;
            end
            dvc_pkg::ST_RX_OWN:
            begin
                if (out_free)
                begin
                    vc_wr_en       = grow;
                    vc_wr_addr     = idx_reg;
                    vc_wr_data     = {((idx_reg == me) ? tv_reg : vc_clk), tv_reg};
                    out_valid_next = 1'b1;
                    out_kind_next  = dvc_pkg::KIND_REPORT;
                    out_idx_next   = XW'(idx_reg);
                    out_val_next   = grow ? tv_reg : ent_clk_reg;
                    out_last_next  = 1'b1;
                end
            end
            dvc_pkg::ST_SEND_TICK:
            begin
                vc_wr_en        = !tick_sat;
                sent_wr_en      = 1'b1;
                own_clk_next    = tick_clk;
                own_stamp_next  = tick_stamp;
                since_next      = since;
                vc_rd_en        = 1'b1;
                vc_rd_addr      = '0;
                rd_cnt_next     = (IW+1)'(1);
                chk_idx_next    = '0;
                chk_valid_next  = 1'b1;
                pend_valid_next = 1'b0;
            end
            dvc_pkg::ST_WALK:
            begin
                if (!walk_stall)
                begin
                    if (cur_sel)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = dvc_pkg::KIND_TUPLE;
                            out_idx_next   = XW'(pend_idx_reg);
                            out_val_next   = pend_val_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_idx_next   = chk_idx_reg;
                        pend_val_next   = cur_clk;
                    end
                    if (walk_more)
                    begin
                        vc_rd_en       = 1'b1;
                        vc_rd_addr     = rd_cnt_reg[IW-1:0];
                        chk_idx_next   = rd_cnt_reg[IW-1:0];
                        chk_valid_next = 1'b1;
                        rd_cnt_next    = rd_cnt_reg + (IW+1)'(1);
                    end
                    else
                    begin
                        chk_valid_next = 1'b0;
                    end
                end
            end
            dvc_pkg::ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_kind_next = dvc_pkg::KIND_TUPLE;
                        out_idx_next  = XW'(pend_idx_reg);
                        out_val_next  = pend_val_reg;
                    end
                    else
                    begin
                        out_kind_next = dvc_pkg::KIND_REPORT;
                        out_idx_next  = XW'(me);
                        out_val_next  = own_clk_reg;
                    end
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // valid bits: an entry never written reads as zero
    always_comb
    begin
        vc_vld_next      = vc_vld_reg;
        sent_vld_next    = sent_vld_reg;
        vc_rd_vld_next   = vc_rd_vld_reg;
        sent_rd_vld_next = sent_rd_vld_reg;
        if (vc_wr_en)
        begin
            vc_vld_next[vc_wr_addr] = 1'b1;
        end
        if (sent_wr_en)
        begin
            sent_vld_next[sent_wr_addr] = 1'b1;
        end
        if (vc_rd_en)
        begin
            vc_rd_vld_next = vc_vld_reg[vc_rd_addr];
        end
        if (sent_rd_en)
        begin
            sent_rd_vld_next = sent_vld_reg[sent_rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= dvc_pkg::ST_IDLE;
            own_id_reg      <= '0;
            vc_vld_reg      <= '0;
            sent_vld_reg    <= '0;
            vc_rd_vld_reg   <= 1'b0;
            sent_rd_vld_reg <= 1'b0;
            chk_valid_reg   <= 1'b0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                own_id_reg <= cfg_data;
            end
            vc_vld_reg      <= vc_vld_next;
            sent_vld_reg    <= sent_vld_next;
            vc_rd_vld_reg   <= vc_rd_vld_next;
            sent_rd_vld_reg <= sent_rd_vld_next;
            chk_valid_reg   <= chk_valid_next;
            pend_valid_reg  <= pend_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dest_reg      <= dest_next;
        idx_reg       <= idx_next;
        tv_reg        <= tv_next;
        ent_clk_reg   <= ent_clk_next;
        own_clk_reg   <= own_clk_next;
        own_stamp_reg <= own_stamp_next;
        since_reg     <= since_next;
        rd_cnt_reg    <= rd_cnt_next;
        chk_idx_reg   <= chk_idx_next;
        pend_idx_reg  <= pend_idx_next;
        pend_val_reg  <= pend_val_next;
        out_kind_reg  <= out_kind_next;
        out_idx_reg   <= out_idx_next;
        out_val_reg   <= out_val_next;
        out_last_reg  <= out_last_next;
    end

endmodule

/* design/dvc_checker.sv */
// port-level checker of the differential vector clock, with its bind
`include "differential_vector_clock_macros.svh"

module dvc_checker #(
    parameter int NUM_PROCESSES = dvc_pkg::DEFAULT_NUM_PROCESSES
) (
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_ready,
    input logic        result_valid,
    input logic        result_ready,
    input logic        kind,
    input logic [3:0]  entry_index,
    input logic [31:0] entry_value,
    input logic        last
);

    localparam int NENT = (NUM_PROCESSES < dvc_pkg::IDX_LIMIT) ?
                          NUM_PROCESSES : dvc_pkg::IDX_LIMIT;

    logic [37:0] beat;
    logic        stalled;
    logic        taken;
    logic        report;

    assign beat    = {kind, entry_index, entry_value, last};
    assign stalled = result_valid && !result_ready;
    assign taken   = item_valid && item_ready;
    assign report  = result_valid && (kind == dvc_pkg::KIND_REPORT);

    `DVC_ASSERT_NEXT(a_result_hold, stalled, result_valid && $stable(beat), "held beat changed")

    `DVC_ASSERT_NEXT(a_one_item_at_a_time, taken, !item_ready, "item taken while busy")

    `DVC_ASSERT_NOW(a_report_is_last, report, last, "report beat not marked last")

    `DVC_ASSERT_NOW(a_index_in_range, result_valid, 5'(entry_index) < 5'(NENT), "index out of range")

endmodule

bind differential_vector_clock dvc_checker #(
    .NUM_PROCESSES (NUM_PROCESSES)
) u_dvc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .kind         (kind),
    .entry_index  (entry_index),
    .entry_value  (entry_value),
    .last         (last)
);

/* tb/dvc_checker.sv */
`timescale 1ns / 100ps
// checker for the differential vector clock: predicts and compares every result beat
module dvc_tb_checker #(
    parameter int NUM_PROCESSES = dvc_pkg::DEFAULT_NUM_PROCESSES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [3:0]  cfg_data,
    input  logic        item_valid,
    input  logic        item_ready,
    input  logic [1:0]  func,
    input  logic [3:0]  destination,
    input  logic [3:0]  tuple_index,
    input  logic [31:0] tuple_value,
    input  logic        result_valid,
    input  logic        result_ready,
    input  logic        kind,
    input  logic [3:0]  entry_index,
    input  logic [31:0] entry_value,
    input  logic        last,
    output int          mismatches,
    output int          outstanding,
    output int          beats_checked,
    output int          tuple_beats,
    output int          empty_sends
);

    localparam int IDX_LIMIT = dvc_pkg::IDX_LIMIT;
    localparam int IDX_W     = dvc_pkg::IDX_W;
    localparam int CLK_W     = dvc_pkg::CLK_W;
    localparam int ENTRIES   = (NUM_PROCESSES < IDX_LIMIT) ? NUM_PROCESSES : IDX_LIMIT;
    localparam int QDEPTH    = 64;
    localparam logic [CLK_W-1:0] CLK_SAT = '1;

    typedef struct packed {
        logic             kind;
        logic [IDX_W-1:0] index;
        logic [CLK_W-1:0] value;
        logic             last;
    } beat_t;

    logic [CLK_W-1:0] vclock   [IDX_LIMIT];
    logic [CLK_W-1:0] grown_at [IDX_LIMIT];
    logic [CLK_W-1:0] sent_at  [IDX_LIMIT];
    logic [IDX_W-1:0] own_id;
    beat_t            expected_beats [QDEPTH];
    int               exp_head;
    int               exp_tail;

    function automatic logic [IDX_W-1:0] fold(input logic [IDX_W-1:0] v);
        return IDX_W'(v % ENTRIES);
    endfunction

    function automatic beat_t make_beat(input logic k, input logic [IDX_W-1:0] ix,
                                        input logic [CLK_W-1:0] val, input logic fin);
        beat_t b;
        b.kind  = k;
        b.index = ix;
        b.value = val;
        b.last  = fin;
        return b;
    endfunction

    task automatic expect_beat(input beat_t b);
        expected_beats[exp_tail % QDEPTH] = b;
        exp_tail++;
    endtask

    task automatic tick_own(input logic [IDX_W-1:0] me);
        if (vclock[me] != CLK_SAT)
        begin
            vclock[me]   = vclock[me] + 1'b1;
            grown_at[me] = vclock[me];
        end
    endtask

    task automatic predict_clock_event(input dvc_pkg::func_t f, input logic [IDX_W-1:0] dest,
                                       input logic [IDX_W-1:0] tidx,
                                       input logic [CLK_W-1:0] tval);
        logic [IDX_W-1:0] me;
        logic [IDX_W-1:0] d;
        logic [IDX_W-1:0] ti;
        logic [CLK_W-1:0] since;
        int               n;
        int               k;
        me = fold(own_id);
        case (f)
            dvc_pkg::FUNC_SEND:
            begin
                d = fold(dest);
                tick_own(me);
                since = sent_at[d];
                n = 0;
                for (int i = 0; i < ENTRIES; i++)
                    if (since < grown_at[i])
                        n++;
                k = 0;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (since < grown_at[i])
                    begin
                        k++;
                        expect_beat(make_beat(dvc_pkg::KIND_TUPLE, IDX_W'(i), vclock[i],
                                              k == n));
                        tuple_beats++;
                    end
                end
                sent_at[d] = vclock[me];
                if (n == 0)
                begin
                    expect_beat(make_beat(dvc_pkg::KIND_REPORT, me, vclock[me], 1'b1));
                    empty_sends++;
                end
            end
            dvc_pkg::FUNC_TUPLE:
            begin
                ti = fold(tidx);
                if (vclock[ti] < tval)
                begin
                    vclock[ti]   = tval;
                    grown_at[ti] = vclock[me];
                end
                expect_beat(make_beat(dvc_pkg::KIND_REPORT, ti, vclock[ti], 1'b1));
            end
            default:
            begin
                tick_own(me);
                expect_beat(make_beat(dvc_pkg::KIND_REPORT, me, vclock[me], 1'b1));
            end
        endcase
    endtask

    task automatic check_beat(input beat_t got);
        beat_t want;
        beats_checked++;
        if (exp_head == exp_tail)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected beat kind=%0d index=%0d value=%0h last=%0d",
                         $realtime, got.kind, got.index, got.value, got.last);
        end
        else
        begin
            want = expected_beats[exp_head % QDEPTH];
            exp_head++;
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: expected %0d/%0d/%0h/%0d, got %0d/%0d/%0h/%0d",
                             $realtime, want.kind, want.index, want.value, want.last,
                             got.kind, got.index, got.value, got.last);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < IDX_LIMIT; i++)
            begin
                vclock[i]   = '0;
                grown_at[i] = '0;
                sent_at[i]  = '0;
            end
            own_id = '0;
            exp_head      = 0;
            exp_tail      = 0;
            mismatches    = 0;
            outstanding   = 0;
            beats_checked = 0;
            tuple_beats   = 0;
            empty_sends   = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                own_id = cfg_data;
            if (item_valid && item_ready)
                predict_clock_event(dvc_pkg::func_t'(func), destination, tuple_index,
                                    tuple_value);
            if (result_valid && result_ready)
                check_beat(make_beat(kind, entry_index, entry_value, last));
            outstanding = exp_tail - exp_head;
        end
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// testbench top for the differential vector clock: stimulus, flow control and verdict
module testbench;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int RANDOM_PER_PHASE = 47;
    localparam int HOLD_CYCLES      = 400;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_data;
    logic        item_valid;
    logic        item_ready;
    logic [1:0]  func;
    logic [3:0]  destination;
    logic [3:0]  tuple_index;
    logic [31:0] tuple_value;
    logic        result_valid;
    logic        result_ready;
    logic        kind;
    logic [3:0]  entry_index;
    logic [31:0] entry_value;
    logic        last;

    int          mismatches;
    int          outstanding;
    int          beats_checked;
    int          tuple_beats;
    int          empty_sends;

    int          cycle_count = 0;
    int          items_sent  = 0;
    int          sends_sent  = 0;
    int          burst_left  = 0;
    bit          hold_request = 1'b0;

    differential_vector_clock u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .func         (func),
        .destination  (destination),
        .tuple_index  (tuple_index),
        .tuple_value  (tuple_value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .kind         (kind),
        .entry_index  (entry_index),
        .entry_value  (entry_value),
        .last         (last)
    );

    dvc_tb_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .func          (func),
        .destination   (destination),
        .tuple_index   (tuple_index),
        .tuple_value   (tuple_value),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .kind          (kind),
        .entry_index   (entry_index),
        .entry_value   (entry_value),
        .last          (last),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .beats_checked (beats_checked),
        .tuple_beats   (tuple_beats),
        .empty_sends   (empty_sends)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result side: random stall patterns plus one long hold-off on request
    initial
    begin
        int hold_left;
        int pattern_left;
        int mode;
        hold_left    = 0;
        pattern_left = 0;
        mode         = 0;
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    mode         = $urandom_range(0, 3);
                    pattern_left = $urandom_range(4, 40);
                end
                pattern_left--;
                case (mode)
                    0:       result_ready <= 1'b1;
                    1:       result_ready <= 1'($urandom_range(0, 1));
                    2:       result_ready <= ($urandom_range(0, 3) == 0);
                    default: result_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    task automatic drive_item(input dvc_pkg::func_t f, input logic [3:0] dest,
                              input logic [3:0] tidx, input logic [31:0] tval);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            repeat (gap)
            begin
                @(negedge clk);
                item_valid <= 1'b0;
            end
        end
        @(negedge clk);
        item_valid  <= 1'b1;
        func        <= f;
        destination <= dest;
        tuple_index <= tidx;
        tuple_value <= tval;
        do
            @(posedge clk);
        while (!item_ready);
        burst_left--;
        items_sent++;
        if (f == dvc_pkg::FUNC_SEND)
            sends_sent++;
    endtask

    task automatic settle();
        @(negedge clk);
        item_valid <= 1'b0;
        wait (outstanding == 0);
    endtask

    task automatic write_own_id(input logic [3:0] id);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= id;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_clock_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return $urandom();
        else if (r < 9)
            return 32'hFFFF_FFFF - $urandom_range(0, 3);
        else
            return $urandom_range(0, 40 + items_sent);
    endfunction

    // mostly well-formed message receipts, sends and internal events, with stray tuples and receive begins mixed in
    task automatic random_phase(input int count, input bit with_hold);
        int start;
        int r;
        int n_tuples;
        bit hold_asked;
        start      = items_sent;
        hold_asked = 1'b0;
        while (items_sent - start < count)
        begin
            if (with_hold && !hold_asked && items_sent - start >= 10)
            begin
                hold_asked   = 1'b1;
                hold_request = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 30)
            begin
                drive_item(dvc_pkg::FUNC_RECV_BEGIN, 4'($urandom()), 4'($urandom()),
                           $urandom());
                n_tuples = $urandom_range(1, 4);
                repeat (n_tuples)
                    drive_item(dvc_pkg::FUNC_TUPLE, 4'($urandom()), 4'($urandom()),
                               pick_clock_value());
            end
            else if (r < 55)
                drive_item(dvc_pkg::FUNC_SEND, 4'($urandom()), 4'($urandom()), $urandom());
            else if (r < 80)
                drive_item(dvc_pkg::FUNC_INTERNAL, 4'($urandom()), 4'($urandom()),
                           $urandom());
            else if (r < 92)
                drive_item(dvc_pkg::FUNC_TUPLE, 4'($urandom()), 4'($urandom()),
                           pick_clock_value());
            else
                drive_item(dvc_pkg::FUNC_RECV_BEGIN, 4'($urandom()), 4'($urandom()),
                           $urandom());
        end
    endtask

    initial
    begin
        logic [3:0] phase_ids [5];
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        item_valid   = 1'b0;
        func         = '0;
        destination  = '0;
        tuple_index  = '0;
        tuple_value  = '0;
        phase_ids[0] = 4'd5;
        phase_ids[1] = 4'd0;
        phase_ids[2] = 4'($urandom());
        phase_ids[3] = 4'd15;
        phase_ids[4] = 4'($urandom());
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // own id from reset
        drive_item(dvc_pkg::FUNC_INTERNAL,   4'd0,  4'd0,  32'd0);
        drive_item(dvc_pkg::FUNC_RECV_BEGIN, 4'd15, 4'd15, 32'hFFFF_FFFF);
        drive_item(dvc_pkg::FUNC_SEND,       4'd0,  4'd0,  32'd0);
        drive_item(dvc_pkg::FUNC_SEND,       4'd15, 4'd0,  32'd0);
        drive_item(dvc_pkg::FUNC_SEND,       4'd15, 4'd0,  32'd0);
        drive_item(dvc_pkg::FUNC_TUPLE,      4'd0,  4'd15, 32'hFFFF_FFFF);
        drive_item(dvc_pkg::FUNC_TUPLE,      4'd0,  4'd15, 32'd5);
        drive_item(dvc_pkg::FUNC_TUPLE,      4'd0,  4'd0,  32'd0);
        drive_item(dvc_pkg::FUNC_SEND,       4'd3,  4'd0,  32'd0);
        drive_item(dvc_pkg::FUNC_TUPLE,      4'd0,  4'd7,  32'hFFFF_FFFE);
        settle();

        // own entry already saturated: ticks hold, second send has nothing new
        write_own_id(4'd15);
        drive_item(dvc_pkg::FUNC_INTERNAL,   4'd0,  4'd0,  32'd0);
        drive_item(dvc_pkg::FUNC_SEND,       4'd9,  4'd0,  32'd0);
        drive_item(dvc_pkg::FUNC_SEND,       4'd9,  4'd0,  32'd0);
        drive_item(dvc_pkg::FUNC_RECV_BEGIN, 4'd0,  4'd0,  32'd0);
        drive_item(dvc_pkg::FUNC_TUPLE,      4'd0,  4'd15, 32'd0);
        drive_item(dvc_pkg::FUNC_SEND,       4'd0,  4'd0,  32'd0);

        for (int p = 0; p < 5; p++)
        begin
            settle();
            write_own_id(phase_ids[p]);
            random_phase(RANDOM_PER_PHASE, p == 1);
        end
        settle();
        repeat (40) @(posedge clk);

        $display("covered %0d items, %0d sends, %0d of them with nothing new to send",
                 items_sent, sends_sent, empty_sends);
        $display("own ids 0, 15, 5 and two random; %0d beats, %0d tuples, %0d-cycle stall",
                 beats_checked, tuple_beats, HOLD_CYCLES);
        if (mismatches == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* differential_vector_clock.f */
+incdir+design
design/dvc_pkg.sv
design/dvc_ram.sv
design/differential_vector_clock.sv
design/dvc_checker.sv
tb/dvc_checker.sv
tb/testbench.sv
